// ===== design/rfnp_pkg.sv =====
// Types and constants for the radius filter nearest point unit.
`timescale 1ns / 1ps

package rfnp_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadiusW  = 31;
  localparam int unsigned IntenW   = 16;
  localparam int unsigned ClassW   = 8;
  localparam int unsigned DistW    = 63;
  localparam int unsigned SqW      = 62;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 184;

  localparam logic [CfgIdxW-1:0] CFG_CENTER_X      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEARCH_RADIUS = 2'd2;

  typedef enum logic {
    KIND_POINT   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [ClassW-1:0] point_class;
    logic [IntenW-1:0] intensity;
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } point_t;

endpackage

// ===== design/radius_filter_nearest_point_unit.sv =====
// Radius filter with nearest point tracking: four stages then a result register.
// An item passes stages a-d and the result register. Throughput: one item per cycle
// unless stalled; an inside set-ending point sends a point result then a summary.
// Reset (rst_ni low, async): zeroes valids, config, phase and nearest-point state.
// A register write reaches radius_q, then the registered radius-squared term r2_q.
`timescale 1ns / 1ps

module radius_filter_nearest_point_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rfnp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rfnp_pkg::CoordW-1:0]     cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_x, point_y, point_z, intensity, point_class
  input  logic [rfnp_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_x, out_y, out_z, out_intensity, out_class, distance_sq, found
  output logic [rfnp_pkg::OutDataW-1:0]   m_axis_tdata,
  // result_kind
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int unsigned CW = rfnp_pkg::CoordW;

  logic [CW-1:0]                   center_x_q, center_y_q;
  logic [rfnp_pkg::RadiusW-1:0]    radius_q;
  logic [rfnp_pkg::SqW-1:0]        r2_q;

  logic                            a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  rfnp_pkg::point_t                a_pt_q, b_pt_q, c_pt_q, d_pt_q;
  logic                            a_end_q, b_end_q, c_end_q, d_end_q;
  logic [CW-2:0]                   b_ax_q, b_ay_q;
  logic                            b_far_q, c_far_q;
  logic [rfnp_pkg::SqW-1:0]        c_sqx_q, c_sqy_q;
  logic [rfnp_pkg::DistW-1:0]      d_dist_q;
  logic                            d_inside_q;
  logic                            phase_q;

  rfnp_pkg::point_t                best_pt_q;
  logic [rfnp_pkg::DistW-1:0]      best_dist_q;
  logic                            have_best_q;

  logic                            out_valid_q;
  rfnp_pkg::point_t                out_pt_q;
  logic [rfnp_pkg::DistW-1:0]      out_dist_q;
  logic                            out_found_q;
  rfnp_pkg::result_kind_e          out_kind_q;
  logic                            out_last_q;

  logic [CW:0]                     dx, dy, ax, ay;
  logic [rfnp_pkg::DistW-1:0]      dist_sum;
  logic                            emit_point, emit_sum, emit_any, emit_last;
  logic                            out_can, out_load, d_done, adv, take_best;

  // config registers and radius squared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      r2_q       <= '0;
    end else begin
      r2_q <= {{(rfnp_pkg::SqW-rfnp_pkg::RadiusW){1'b0}}, radius_q} *
              {{(rfnp_pkg::SqW-rfnp_pkg::RadiusW){1'b0}}, radius_q};
      if (cfg_we_i) begin
        case (cfg_index_i)
          rfnp_pkg::CFG_CENTER_X:      center_x_q <= cfg_data_i;
          rfnp_pkg::CFG_CENTER_Y:      center_y_q <= cfg_data_i;
          rfnp_pkg::CFG_SEARCH_RADIUS: radius_q   <= cfg_data_i[rfnp_pkg::RadiusW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_comb begin
    dx = {a_pt_q.x[CW-1], a_pt_q.x} - {center_x_q[CW-1], center_x_q};
    dy = {a_pt_q.y[CW-1], a_pt_q.y} - {center_y_q[CW-1], center_y_q};
    ax = dx[CW] ? (-dx) : dx;
    ay = dy[CW] ? (-dy) : dy;
    dist_sum = {1'b0, c_sqx_q} + {1'b0, c_sqy_q};
  end

  // result sequencing
  always_comb begin
    emit_point = d_valid_q && d_inside_q && !phase_q;
    emit_sum   = d_valid_q && d_end_q && (phase_q || !d_inside_q);
    emit_any   = emit_point || emit_sum;
    emit_last  = emit_sum || (emit_point && !d_end_q);
    out_can    = !out_valid_q || m_axis_tready;
    out_load   = emit_any && out_can;
    d_done     = d_valid_q && (!emit_any || (out_can && emit_last));
    adv        = !d_valid_q || d_done;
    take_best  = out_load && emit_point && (!have_best_q || d_dist_q < best_dist_q);
  end

  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= s_axis_tvalid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_pt_q     <= s_axis_tdata;
      a_end_q    <= s_axis_tlast;
      b_pt_q     <= a_pt_q;
      b_end_q    <= a_end_q;
      b_ax_q     <= ax[CW-2:0];
      b_ay_q     <= ay[CW-2:0];
      b_far_q    <= (ax[CW:CW-1] != 2'b00) || (ay[CW:CW-1] != 2'b00);
      c_pt_q     <= b_pt_q;
      c_end_q    <= b_end_q;
      c_far_q    <= b_far_q;
      c_sqx_q    <= {{(rfnp_pkg::SqW-(CW-1)){1'b0}}, b_ax_q} *
                    {{(rfnp_pkg::SqW-(CW-1)){1'b0}}, b_ax_q};
      c_sqy_q    <= {{(rfnp_pkg::SqW-(CW-1)){1'b0}}, b_ay_q} *
                    {{(rfnp_pkg::SqW-(CW-1)){1'b0}}, b_ay_q};
      d_pt_q     <= c_pt_q;
      d_end_q    <= c_end_q;
      d_dist_q   <= dist_sum;
      d_inside_q <= !c_far_q && (dist_sum < {1'b0, r2_q});
    end
  end

  // second result of an item pending
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (d_done) begin
      phase_q <= 1'b0;
    end else if (out_load && emit_point) begin
      phase_q <= 1'b1;
    end
  end

  // nearest point state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_pt_q   <= '0;
      best_dist_q <= '0;
      have_best_q <= 1'b0;
    end else if (take_best) begin
      best_pt_q   <= d_pt_q;
      best_dist_q <= d_dist_q;
      have_best_q <= 1'b1;
    end else if (out_load && emit_sum) begin
      best_pt_q   <= '0;
      best_dist_q <= '0;
      have_best_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_last_q <= emit_last;
      if (emit_point) begin
        out_kind_q  <= rfnp_pkg::KIND_POINT;
        out_pt_q    <= d_pt_q;
        out_dist_q  <= d_dist_q;
        out_found_q <= 1'b0;
      end else begin
        out_kind_q  <= rfnp_pkg::KIND_SUMMARY;
        out_pt_q    <= best_pt_q;
        out_dist_q  <= best_dist_q;
        out_found_q <= have_best_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_found_q, out_dist_q, out_pt_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_phase_only_split : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (d_valid_q && d_inside_q && d_end_q))
    else $error("pending second result without an inside set-end item");

  a_point_not_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == rfnp_pkg::KIND_POINT) |-> (!out_found_q && !out_last_q ||
      !out_found_q && out_last_q))
    else $error("point result carries found flag");

  a_empty_summary_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == rfnp_pkg::KIND_SUMMARY && !out_found_q) |->
      (out_dist_q == '0 && out_pt_q == '0 && out_last_q))
    else $error("empty summary is not all zero");

  a_best_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_best_q |-> (best_dist_q == '0 && best_pt_q == '0))
    else $error("nearest point state not cleared");
`endif

endmodule
